// ===== hw/rtl/lvmg_pkg.sv =====
// Package: shared types and constants of the label volume max grow block.
package lvmg_pkg;

  localparam int LABEL_W = 32;
  localparam logic [LABEL_W-1:0] FIXED_BIT = 32'h8000_0000;

  localparam logic CMD_VOXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef enum logic [1:0] {
    REG_SIZE_X    = 2'd0,
    REG_SIZE_Y    = 2'd1,
    REG_SIZE_Z    = 2'd2,
    REG_PASS_MODE = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic               cmd;
    logic [LABEL_W-1:0] label;
  } in_t;

  typedef struct packed {
    logic [LABEL_W-1:0] new_label;
    logic               last;
  } out_t;

  // position of the voxel being computed
  typedef struct packed {
    logic [8:0]  x;
    logic [8:0]  y;
    logic [12:0] z;
    logic        last;
  } pos_t;

endpackage

// ===== hw/rtl/label_volume_max_grow.sv =====
// Top level: request control, position counters, result pipeline and configuration.
// One request per cycle unless the output stalls: voxels and flush ticks stream at full
// rate; each result passes the s1 and output registers, lagging the input by one plane,
// one row and one voxel. The neighbourhood comes from two plane delay lines and six row
// delay lines, each a ring memory with one write and one registered read per shift.
// Flush ticks drain the results pending after the last voxel. If a volume holds fewer
// voxels than one plane plus one row plus one voxel, the block inserts zero fill shifts
// after its last voxel until that count is reached, during which no request is taken.
module label_volume_max_grow #(
  parameter int MAX_ROW  = 256,
  parameter int MAX_ROWS = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lvmg_pkg::in_t      in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output lvmg_pkg::out_t     out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [12:0]        cfg_wdata
);
  import lvmg_pkg::*;

  localparam int ROW_CAP   = (MAX_ROW > 511) ? 511 : MAX_ROW;
  localparam int ROWS_CAP  = (MAX_ROWS > 511) ? 511 : MAX_ROWS;
  localparam int PLANE_CAP = ROW_CAP * ROWS_CAP;
  localparam int RAW       = $clog2(ROW_CAP);
  localparam int PAW       = $clog2(PLANE_CAP);
  localparam logic [8:0] ROW_LIM  = 9'(ROW_CAP);
  localparam logic [8:0] ROWS_LIM = 9'(ROWS_CAP);

  logic [8:0]  size_x_r, size_y_r;
  logic [12:0] size_z_r;
  logic        mode_r;

  logic [8:0]  sx, sy;
  logic [12:0] sz;
  logic [17:0] sxy;
  logic [18:0] lag;

  logic [8:0]  ix_r, iy_r, ox_r, oy_r;
  logic [12:0] iz_r, oz_r;
  logic        in_done_r;
  logic [18:0] d_r;

  logic        s1_v_r, out_valid_r;
  pos_t        s1_pos_r;
  out_t        out_r;

  logic        advance, acc, is_vox, shift_in, pad, shift, emit;
  logic        in_last, out_last;
  logic [18:0] d_inc;
  logic [31:0] din, pick_label;
  logic [26:0][31:0] win;

  always_comb begin
    sx = (size_x_r == '0) ? 9'd1 : ((size_x_r > ROW_LIM) ? ROW_LIM : size_x_r);
    sy = (size_y_r == '0) ? 9'd1 : ((size_y_r > ROWS_LIM) ? ROWS_LIM : size_y_r);
    sz = (size_z_r == '0) ? 13'd1 : ((size_z_r > 13'd4096) ? 13'd4096 : size_z_r);
    sxy = sx * sy;
    lag = {1'b0, sxy} + {10'd0, sx} + 19'd1;
  end

  assign advance  = !out_valid_r || out_ready;
  // after the last voxel, fill until the window reaches the first pending result
  assign pad      = in_done_r && (d_r < lag) && !s1_v_r;
  assign in_ready = advance && !(in_done_r && (d_r < lag));
  assign acc      = in_valid && in_ready;
  assign is_vox   = (in_data.cmd == CMD_VOXEL);
  assign shift_in = acc && (is_vox ? !in_done_r : in_done_r);
  assign d_inc    = d_r + 19'd1;
  assign emit     = shift_in && (d_inc > lag);
  assign shift    = shift_in || pad;
  assign din      = (shift_in && is_vox) ? in_data.label : '0;
  assign in_last  = (ix_r == sx - 9'd1) && (iy_r == sy - 9'd1) && (iz_r == sz - 13'd1);
  assign out_last = (ox_r == sx - 9'd1) && (oy_r == sy - 9'd1) && (oz_r == sz - 13'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r    <= 9'd256;
      size_y_r    <= 9'd256;
      size_z_r    <= 13'd256;
      mode_r      <= 1'b0;
      ix_r        <= '0;
      iy_r        <= '0;
      iz_r        <= '0;
      ox_r        <= '0;
      oy_r        <= '0;
      oz_r        <= '0;
      in_done_r   <= 1'b0;
      d_r         <= '0;
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        s1_v_r      <= emit;
        out_valid_r <= s1_v_r;
      end
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_SIZE_X:    size_x_r <= cfg_wdata[8:0];
          REG_SIZE_Y:    size_y_r <= cfg_wdata[8:0];
          REG_SIZE_Z:    size_z_r <= cfg_wdata;
          REG_PASS_MODE: mode_r   <= cfg_wdata[0];
          default:       mode_r   <= mode_r;
        endcase
        ix_r      <= '0;
        iy_r      <= '0;
        iz_r      <= '0;
        ox_r      <= '0;
        oy_r      <= '0;
        oz_r      <= '0;
        in_done_r <= 1'b0;
        d_r       <= '0;
      end else begin
        if (pad) d_r <= d_inc;
        if (shift_in) begin
          if (!emit) d_r <= d_inc;
          if (is_vox) begin
            in_done_r <= in_last;
            if (ix_r == sx - 9'd1) begin
              ix_r <= '0;
              if (iy_r == sy - 9'd1) begin
                iy_r <= '0;
                iz_r <= iz_r + 13'd1;
              end else begin
                iy_r <= iy_r + 9'd1;
              end
            end else begin
              ix_r <= ix_r + 9'd1;
            end
          end
        end
        if (emit) begin
          if (out_last) begin
            ix_r      <= '0;
            iy_r      <= '0;
            iz_r      <= '0;
            ox_r      <= '0;
            oy_r      <= '0;
            oz_r      <= '0;
            in_done_r <= 1'b0;
            d_r       <= '0;
          end else if (ox_r == sx - 9'd1) begin
            ox_r <= '0;
            if (oy_r == sy - 9'd1) begin
              oy_r <= '0;
              oz_r <= oz_r + 13'd1;
            end else begin
              oy_r <= oy_r + 9'd1;
            end
          end else begin
            ox_r <= ox_r + 9'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (emit) s1_pos_r <= '{x: ox_r, y: oy_r, z: oz_r, last: out_last};
      if (s1_v_r) out_r <= '{new_label: pick_label, last: s1_pos_r.last};
    end
  end

  lvmg_window #(
    .ROW_DEPTH  (ROW_CAP),
    .PLANE_DEPTH(PLANE_CAP)
  ) u_window (
    .clk,
    .rst_n,
    .clr      (cfg_we),
    .shift,
    .row_len  (RAW'(sx - 9'd1)),
    .plane_len(PAW'(sxy - 18'd1)),
    .din,
    .win
  );

  lvmg_pick u_pick (
    .win,
    .pos  (s1_pos_r),
    .sx,
    .sy,
    .sz,
    .mode (mode_r),
    .label(pick_label)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_pad_no_request: assert property (@(posedge clk) disable iff (!rst_n)
    pad |-> !in_ready)
    else $error("fill shift overlaps an accepted request");

  a_lag_bound: assert property (@(posedge clk) disable iff (!rst_n)
    d_r <= lag)
    else $error("window lead exceeds one plane, one row and one voxel");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && out_last && !cfg_we) |=> (d_r == '0 && !in_done_r && ix_r == '0))
    else $error("positions not cleared after the final voxel");

endmodule

// ===== hw/rtl/lvmg_delay.sv =====
// Variable-length delay line on a ring memory with registered read.
module lvmg_delay #(
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          clr,
  input  logic          shift,
  input  logic [AW-1:0] len,
  input  logic [31:0]   din,
  output logic [31:0]   dout
);

  logic [31:0]   mem [DEPTH];
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [31:0]   dout_r;

  always_comb begin
    ptr_nxt = ptr_r;
    if (shift) begin
      if (len == '0 || ptr_r == len - AW'(1)) ptr_nxt = '0;
      else ptr_nxt = ptr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      ptr_r <= '0;
    end else begin
      ptr_r <= ptr_nxt;
    end
  end

  // zero length: the output register alone gives one shift of delay
  always_ff @(posedge clk) begin
    if (shift) begin
      mem[ptr_r] <= din;
      dout_r     <= (len == '0) ? din : mem[ptr_r];
    end
  end

  assign dout = dout_r;

endmodule

// ===== hw/rtl/lvmg_window.sv =====
// 3x3x3 neighbourhood window: row and plane delay lines plus column shift registers.
module lvmg_window #(
  parameter int ROW_DEPTH   = 256,
  parameter int PLANE_DEPTH = 65536,
  parameter int RAW         = $clog2(ROW_DEPTH),
  parameter int PAW         = $clog2(PLANE_DEPTH)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 clr,
  input  logic                 shift,
  input  logic [RAW-1:0]       row_len,
  input  logic [PAW-1:0]       plane_len,
  input  logic [31:0]          din,
  output logic [26:0][31:0]    win
);

  // tap j: dz = 1 - j/3, dy = 1 - j%3, dx = +1
  logic [31:0] tap [9];
  logic [31:0] t0_r;
  logic [31:0] w1_r [9];
  logic [31:0] w2_r [9];

  always_ff @(posedge clk) begin
    if (shift) t0_r <= din;
  end
  assign tap[0] = t0_r;

  lvmg_delay #(.DEPTH(PLANE_DEPTH)) u_plane0 (
    .clk, .rst_n, .clr, .shift, .len(plane_len), .din(tap[0]), .dout(tap[3]));
  lvmg_delay #(.DEPTH(PLANE_DEPTH)) u_plane1 (
    .clk, .rst_n, .clr, .shift, .len(plane_len), .din(tap[3]), .dout(tap[6]));

  for (genvar p = 0; p < 3; p++) begin : g_plane
    lvmg_delay #(.DEPTH(ROW_DEPTH)) u_row0 (
      .clk, .rst_n, .clr, .shift, .len(row_len), .din(tap[3*p]), .dout(tap[3*p+1]));
    lvmg_delay #(.DEPTH(ROW_DEPTH)) u_row1 (
      .clk, .rst_n, .clr, .shift, .len(row_len), .din(tap[3*p+1]), .dout(tap[3*p+2]));
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      for (int j = 0; j < 9; j++) begin
        w1_r[j] <= tap[j];
        w2_r[j] <= w1_r[j];
      end
    end
  end

  for (genvar zi = 0; zi < 3; zi++) begin : g_z
    for (genvar yi = 0; yi < 3; yi++) begin : g_y
      assign win[zi*9 + yi*3 + 2] = tap[(2-zi)*3 + (2-yi)];
      assign win[zi*9 + yi*3 + 1] = w1_r[(2-zi)*3 + (2-yi)];
      assign win[zi*9 + yi*3 + 0] = w2_r[(2-zi)*3 + (2-yi)];
    end
  end

endmodule

// ===== hw/rtl/lvmg_pick.sv =====
// New label of one voxel from its window: bounds mask and maximum tree.
module lvmg_pick (
  input  logic [26:0][31:0] win,
  input  lvmg_pkg::pos_t    pos,
  input  logic [8:0]        sx,
  input  logic [8:0]        sy,
  input  logic [12:0]       sz,
  input  logic              mode,
  output logic [31:0]       label
);
  import lvmg_pkg::*;

  logic [2:0]  xv, yv, zv;
  logic [31:0] c;
  logic [31:0] t32 [32];
  logic [31:0] t16 [16];
  logic [31:0] t8  [8];
  logic [31:0] t4  [4];
  logic [31:0] t2  [2];
  logic [31:0] best;

  always_comb begin
    xv = {({1'b0, pos.x} + 10'd1) < {1'b0, sx}, 1'b1, pos.x != '0};
    yv = {({1'b0, pos.y} + 10'd1) < {1'b0, sy}, 1'b1, pos.y != '0};
    zv = {({1'b0, pos.z} + 14'd1) < {1'b0, sz}, 1'b1, pos.z != '0};
    for (int i = 0; i < 32; i++) begin
      t32[i] = '0;
      if (i < 27) begin
        if (zv[i/9] && yv[(i/3)%3] && xv[i%3] && !win[i][31]) t32[i] = win[i];
      end
    end
    for (int i = 0; i < 16; i++) t16[i] = (t32[2*i] > t32[2*i+1]) ? t32[2*i] : t32[2*i+1];
    for (int i = 0; i < 8; i++)  t8[i]  = (t16[2*i] > t16[2*i+1]) ? t16[2*i] : t16[2*i+1];
    for (int i = 0; i < 4; i++)  t4[i]  = (t8[2*i] > t8[2*i+1]) ? t8[2*i] : t8[2*i+1];
    for (int i = 0; i < 2; i++)  t2[i]  = (t4[2*i] > t4[2*i+1]) ? t4[2*i] : t4[2*i+1];
    best = (t2[0] > t2[1]) ? t2[0] : t2[1];

    // center is unfixed and in bounds, so the tree already covers it
    c = win[13];
    if (c == '0 || (c & FIXED_BIT) != '0) label = c;
    else if (mode) label = c | FIXED_BIT;
    else label = best;
  end

endmodule

// ===== verif/tb_top.sv =====
// Testbench for label_volume_max_grow: scoreboard class, drivers and test sequence.
`timescale 1ns / 1ps

module tb_top;
  import lvmg_pkg::*;

  // Tracks volume state and the queue of labels the block owes.
  class grow_scoreboard;
    int unsigned reg_x = 256, reg_y = 256, reg_z = 256;
    bit mode_final;
    logic [31:0] vox [int];
    int unsigned in_pos, out_pos;
    out_t owed_q[$];
    int errs;

    function int unsigned clamp(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function int unsigned sx(); return clamp(reg_x, 256); endfunction
    function int unsigned sy(); return clamp(reg_y, 256); endfunction
    function int unsigned sz(); return clamp(reg_z, 4096); endfunction
    function int unsigned vol_total(); return sx() * sy() * sz(); endfunction
    function int unsigned lag(); return sx() * sy() + sx() + 1; endfunction

    // results a flush can still drain
    function int unsigned drainable();
      if (in_pos == vol_total() && out_pos < vol_total()) return vol_total() - out_pos;
      return 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [12:0] val);
      case (idx)
        REG_SIZE_X: reg_x = val[8:0];
        REG_SIZE_Y: reg_y = val[8:0];
        REG_SIZE_Z: reg_z = val[12:0];
        REG_PASS_MODE: mode_final = val[0];
      endcase
      in_pos = 0;
      out_pos = 0;
    endfunction

    function logic [31:0] grown_label(int unsigned p);
      int unsigned x, y, z, q;
      int nx, ny, nz;
      logic [31:0] c, best, m;
      x = p % sx();
      y = (p / sx()) % sy();
      z = p / (sx() * sy());
      c = vox[p];
      if (c == 0 || (c & FIXED_BIT) != 0) return c;
      if (mode_final) return c | FIXED_BIT;
      best = c;
      for (int dz = -1; dz <= 1; dz++)
        for (int dy = -1; dy <= 1; dy++)
          for (int dx = -1; dx <= 1; dx++) begin
            nx = int'(x) + dx;
            ny = int'(y) + dy;
            nz = int'(z) + dz;
            if (nx >= 0 && nx < sx() && ny >= 0 && ny < sy() && nz >= 0 && nz < sz()) begin
              q = nz * sx() * sy() + ny * sx() + nx;
              m = vox[q];
              if ((m & FIXED_BIT) == 0 && m > best) best = m;
            end
          end
      return best;
    endfunction

    function void note_request(in_t req);
      bit emit;
      out_t r;
      emit = 0;
      if (req.cmd == CMD_VOXEL) begin
        if (in_pos < vol_total()) begin
          vox[in_pos] = req.label;
          in_pos++;
          if (out_pos < vol_total() && in_pos > out_pos + lag()) emit = 1;
        end
      end else if (drainable() > 0) begin
        emit = 1;
      end
      if (!emit) return;
      r.new_label = grown_label(out_pos);
      r.last = (out_pos == vol_total() - 1);
      owed_q = {owed_q, r};
      out_pos++;
      if (out_pos >= vol_total()) begin
        in_pos = 0;
        out_pos = 0;
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (owed_q.size() == 0) begin
        $error("unexpected result new_label=%h last=%b", got.new_label, got.last);
        errs++;
        return;
      end
      want = owed_q.pop_front();
      if (got.new_label !== want.new_label) begin
        $error("new_label: expected %h, got %h", want.new_label, got.new_label);
        errs++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %b, got %b", want.last, got.last);
        errs++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  in_t in_data;
  out_t out_data;
  logic cfg_we;
  logic [1:0] cfg_addr;
  logic [12:0] cfg_wdata;

  grow_scoreboard sb = new();
  bit calm;
  int sent;

  label_volume_max_grow u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("** label_volume_max_grow: FAILED **");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // result side back-pressure
  initial begin
    out_ready = 0;
    @(posedge rst_n);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_ready <= 0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_ready <= 1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  task automatic send(logic cmd, logic [31:0] lbl);
    in_t req;
    req.cmd = cmd;
    req.label = lbl;
    in_valid <= 1;
    in_data <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(req);
    sent++;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // block must be idle: all results in, plus time for zero fill shifts
  task automatic settle();
    in_valid <= 0;
    @(posedge clk);
    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (sb.lag() + 10) @(posedge clk);
  endtask

  task automatic set_regs(logic [12:0] x, logic [12:0] y, logic [12:0] z, logic m);
    reg_idx_t idx;
    logic [12:0] v;
    settle();
    for (int i = 0; i < 4; i++) begin
      idx = reg_idx_t'(i);
      case (idx)
        REG_SIZE_X: v = x;
        REG_SIZE_Y: v = y;
        REG_SIZE_Z: v = z;
        default: v = {12'd0, m};
      endcase
      cfg_we <= 1;
      cfg_addr <= idx;
      cfg_wdata <= v;
      @(posedge clk);
      sb.write_reg(idx, v);
    end
    cfg_we <= 0;
  endtask

  function automatic logic [31:0] pick_label();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return FIXED_BIT | $urandom_range(0, 30);
      2: return $urandom();
      3: return FIXED_BIT | $urandom();
      default: return $urandom_range(1, 24);
    endcase
  endfunction

  // one volume with optional noise; cut_at < total abandons it early
  task automatic run_volume(bit noisy, int unsigned cut_at);
    int unsigned total;
    total = sb.vol_total();
    for (int unsigned i = 0; i < total && i < cut_at; i++) begin
      if (noisy && $urandom_range(0, 19) == 0) send(CMD_FLUSH, $urandom());
      send(CMD_VOXEL, pick_label());
    end
    if (cut_at < total) return;
    while (sb.drainable() > 0) begin
      if (noisy && $urandom_range(0, 9) == 0) send(CMD_VOXEL, $urandom());
      send(CMD_FLUSH, $urandom());
    end
    if (noisy && $urandom_range(0, 3) == 0) send(CMD_FLUSH, 0);
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    cfg_we = 0;
    cfg_addr = REG_SIZE_X;
    cfg_wdata = 0;
    calm = 0;
    sent = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: zero sizes count as one, single voxel volume drained by flush
    set_regs(13'd0, 13'd0, 13'd0, 1'b0);
    send(CMD_FLUSH, 32'hFFFF_FFFF);
    send(CMD_VOXEL, 32'h7FFF_FFFF);
    send(CMD_VOXEL, 32'h1234_5678);
    send(CMD_FLUSH, 0);
    send(CMD_FLUSH, 0);
    set_regs(13'd3, 13'd3, 13'd3, 1'b0);
    for (int i = 0; i < 27; i++)
      send(CMD_VOXEL, (i == 13) ? 32'h0000_0001 : (i == 0) ? 32'hFFFF_FFFF :
           (i == 26) ? 32'h7FFF_FFFF : (i % 4 == 0) ? 32'd0 : i);
    while (sb.drainable() > 0) send(CMD_FLUSH, 0);
    set_regs(13'd2, 13'd2, 13'd2, 1'b1);
    run_volume(0, ~0);
    // oversized row length clamps to the maximum
    set_regs(13'h1FF, 13'd1, 13'd1, 1'b0);
    run_volume(0, ~0);

    while (sent < 880) begin
      set_regs(13'($urandom_range(0, 5)), 13'($urandom_range(0, 4)),
               13'($urandom_range(0, 3)), $urandom_range(0, 4) == 0);
      if ($urandom_range(0, 7) == 0) run_volume(1, $urandom_range(0, sb.vol_total()));
      repeat ($urandom_range(1, 2)) run_volume($urandom_range(0, 3) == 0, ~0);
      if ($urandom_range(0, 9) == 0) settle();
      if (sent > 780) calm = 1;
    end
    settle();
    in_valid <= 0;
    repeat (50) @(posedge clk);
    if (sb.owed_q.size() != 0) begin
      $error("%0d results never arrived", sb.owed_q.size());
      sb.errs++;
    end
    if (sb.errs == 0)
      $display("** label_volume_max_grow: PASSED **");
    else
      $display("** label_volume_max_grow: FAILED **");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/lvmg_pkg.sv
hw/rtl/lvmg_delay.sv
hw/rtl/lvmg_window.sv
hw/rtl/lvmg_pick.sv
hw/rtl/label_volume_max_grow.sv
verif/tb_top.sv
